FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define MFTR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, quiet during reset
`define MFTR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/mftr_pkg.sv
`default_nettype none

package mftr_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int ID_W        = 6;
    localparam int COUNT_W     = 7;

    localparam logic [2:0] MODE_SEARCH     = 3'd0;
    localparam logic [2:0] MODE_INSERT     = 3'd1;
    localparam logic [2:0] MODE_INSERT_AT  = 3'd2;
    localparam logic [2:0] MODE_DELETE     = 3'd3;
    localparam logic [2:0] MODE_DELETE_ALL = 3'd4;

    typedef enum logic [2:0] {
        OP_SEARCH,
        OP_INSERT,
        OP_INSERT_AT,
        OP_DELETE,
        OP_DELETE_ALL,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        STAT_HIT     = 2'd0,
        STAT_MISS    = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_UNAVAIL = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_HEAD_TAKE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  prot;
    } tuple_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_l4;
        logic [15:0] dst_l4;
        logic [7:0]  proto;
        logic [31:0] mask_src_ip;
        logic [31:0] mask_dst_ip;
        logic [15:0] mask_src_l4;
        logic [15:0] mask_dst_l4;
        logic [7:0]  mask_proto;
        logic [5:0]  position;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    rule_id;
        logic [COUNT_W-1:0] free_count;
    } result_t;

    typedef struct packed {
        op_t        op;
        tuple_t     value;
        tuple_t     mask;
        logic [5:0] position;
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/masked_five_tuple_rule_table.sv
`default_nettype none

// Ternary five-tuple rule table. A request is taken when start is high and busy is low; each
// request gives one result on result, marked by done for exactly one cycle, which the receiver
// cannot stall. Up to three requests are held ahead of the executing one. After dequeue, search
// and delete pass through the match and pick states, insert takes the free-list head, a rejected
// request is answered from idle, insert at position walks the free-list memory one slot per step
// to find the position and shift the rest of the list, and delete all steps through each entry.
module masked_five_tuple_rule_table #(
    parameter int ENTRIES = mftr_pkg::ENTRIES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire mftr_pkg::request_t request,
    output logic                    busy,
    output logic                    done,
    output mftr_pkg::result_t       result
);

    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    mftr_pkg::cmd_t push_cmd;
    mftr_pkg::cmd_t head_cmd;

    mftr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .request    (request),
        .busy       (busy),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    mftr_queue #(
        .DEPTH (mftr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    mftr_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .done        (done),
        .result      (result)
    );

endmodule

`default_nettype wire

FILE: rtl/mftr_front.sv
`default_nettype none

module mftr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mftr_pkg::request_t request,
    output logic                   busy,
    output logic                   push,
    output mftr_pkg::cmd_t         push_cmd,
    input  wire logic              queue_full
);

    logic           stage_valid_reg;
    logic           stage_valid_next;
    mftr_pkg::cmd_t stage_reg;
    mftr_pkg::cmd_t classified;
    logic           accept;

    always_comb
    begin
        classified.value    = {request.src_ip, request.dst_ip, request.src_l4,
                               request.dst_l4, request.proto};
        classified.mask     = {request.mask_src_ip, request.mask_dst_ip,
                               request.mask_src_l4, request.mask_dst_l4,
                               request.mask_proto};
        classified.position = request.position;
        case (request.mode)
            mftr_pkg::MODE_SEARCH:     classified.op = mftr_pkg::OP_SEARCH;
            mftr_pkg::MODE_INSERT:     classified.op = mftr_pkg::OP_INSERT;
            mftr_pkg::MODE_INSERT_AT:  classified.op = mftr_pkg::OP_INSERT_AT;
            mftr_pkg::MODE_DELETE:     classified.op = mftr_pkg::OP_DELETE;
            mftr_pkg::MODE_DELETE_ALL: classified.op = mftr_pkg::OP_DELETE_ALL;
            default:                   classified.op = mftr_pkg::OP_NONE;
        endcase
    end

    assign busy     = stage_valid_reg && queue_full;
    assign accept   = start && !busy;
    assign push     = stage_valid_reg && !queue_full;
    assign push_cmd = stage_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= classified;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mftr_queue.sv
`default_nettype none

module mftr_queue #(
    parameter int DEPTH = mftr_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mftr_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output mftr_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mftr_pkg::cmd_t   slots[DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign head_cmd = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mftr_free_mem.sv
`default_nettype none

module mftr_free_mem #(
    parameter int ENTRIES = mftr_pkg::ENTRIES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       we,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_data,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
    output logic      [$clog2(ENTRIES)-1:0] rd_data
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [IDX_W-1:0]   mem[ENTRIES];
    logic [ENTRIES-1:0] written_reg;
    logic [IDX_W-1:0]   rd_data_reg;

    assign rd_data = rd_data_reg;

    // an unwritten slot holds its own index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (we)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= written_reg[rd_addr] ? mem[rd_addr] : rd_addr;
    end

endmodule

`default_nettype wire

FILE: rtl/mftr_back.sv
`default_nettype none
`include "assert_macros.svh"

module mftr_back #(
    parameter int ENTRIES = mftr_pkg::ENTRIES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           queue_empty,
    input  wire mftr_pkg::cmd_t head_cmd,
    output logic                pop,
    output logic                done,
    output mftr_pkg::result_t   result
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    mftr_pkg::state_t  state_reg;
    mftr_pkg::state_t  state_next;
    mftr_pkg::cmd_t    cmd_reg;
    mftr_pkg::cmd_t    cmd_next;
    logic [ENTRIES-1:0] hit_reg;
    logic [ENTRIES-1:0] hit_next;
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  walk_reg;
    logic [CNT_W-1:0]  walk_next;
    logic              res_valid_reg;
    logic              res_valid_next;
    mftr_pkg::result_t res_reg;
    mftr_pkg::result_t res_next;

    mftr_pkg::tuple_t  value_mem[ENTRIES];
    mftr_pkg::tuple_t  mask_mem[ENTRIES];
    logic              rule_we;
    logic [IDX_W-1:0]  rule_idx;

    logic              fl_we;
    logic [IDX_W-1:0]  fl_wr_addr;
    logic [IDX_W-1:0]  fl_wr_data;
    logic [IDX_W-1:0]  fl_rd_addr;
    logic [IDX_W-1:0]  fl_rd_data;

    logic [ENTRIES-1:0] lowest;
    logic [IDX_W-1:0]  pick_id;
    logic              pick_any;
    logic [IDX_W-1:0]  pos_idx;
    logic              pos_in_range;
    logic [IDX_W-1:0]  flush_idx;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] offset);
        int s;
        s = int'(head) + int'(offset);
        if (s >= ENTRIES)
        begin
            s = s - ENTRIES;
        end
        return IDX_W'(s);
    endfunction

    mftr_free_mem #(
        .ENTRIES (ENTRIES)
    ) u_free_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (fl_we),
        .wr_addr (fl_wr_addr),
        .wr_data (fl_wr_data),
        .rd_addr (fl_rd_addr),
        .rd_data (fl_rd_data)
    );

    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (cmd_reg.op == mftr_pkg::OP_SEARCH)
            begin
                hit_next[e] = valid_reg[e] &&
                    (((cmd_reg.value ^ value_mem[e]) & mask_mem[e]) == '0);
            end
            else
            begin
                hit_next[e] = valid_reg[e] && (cmd_reg.value == value_mem[e]) &&
                    (cmd_reg.mask == mask_mem[e]);
            end
        end
    end

    always_comb
    begin
        lowest   = hit_reg & (~hit_reg + ENTRIES'(1));
        pick_any = |hit_reg;
        pick_id  = '0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            if (lowest[e])
            begin
                pick_id = pick_id | IDX_W'(e);
            end
        end
    end

    assign pos_in_range = (32'(head_cmd.position) < ENTRIES);
    assign pos_idx      = IDX_W'(cmd_reg.position);
    assign flush_idx    = IDX_W'(walk_reg);
    assign pop          = (state_reg == mftr_pkg::ST_IDLE) && !queue_empty;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        valid_next     = valid_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        walk_next      = walk_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        rule_we        = 1'b0;
        rule_idx       = pos_idx;
        fl_we          = 1'b0;
        fl_wr_addr     = slot_of(head_reg, cnt_reg);
        fl_wr_data     = pick_id;
        fl_rd_addr     = slot_of(head_reg, walk_reg);

        case (state_reg)
            mftr_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next  = head_cmd;
                    walk_next = '0;
                    res_next  = '{status: mftr_pkg::STAT_MISS, rule_id: '0,
                                  free_count: mftr_pkg::COUNT_W'(cnt_reg)};
                    case (head_cmd.op)
                        mftr_pkg::OP_SEARCH,
                        mftr_pkg::OP_DELETE:
                        begin
                            state_next = mftr_pkg::ST_MATCH;
                        end
                        mftr_pkg::OP_INSERT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = mftr_pkg::STAT_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                fl_rd_addr = head_reg;
                                state_next = mftr_pkg::ST_HEAD_TAKE;
                            end
                        end
                        mftr_pkg::OP_INSERT_AT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next.status = mftr_pkg::STAT_FULL;
                                res_valid_next  = 1'b1;
                            end
                            else if (!pos_in_range ||
                                     valid_reg[IDX_W'(head_cmd.position)])
                            begin
                                res_next.status = mftr_pkg::STAT_UNAVAIL;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = mftr_pkg::ST_FIND_RD;
                            end
                        end
                        mftr_pkg::OP_DELETE_ALL:
                        begin
                            state_next = mftr_pkg::ST_FLUSH;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            mftr_pkg::ST_MATCH:
            begin
                state_next = mftr_pkg::ST_PICK;
            end

            mftr_pkg::ST_PICK:
            begin
                state_next     = mftr_pkg::ST_IDLE;
                res_valid_next = 1'b1;
                if (pick_any)
                begin
                    res_next.status  = mftr_pkg::STAT_HIT;
                    res_next.rule_id = mftr_pkg::ID_W'(pick_id);
                    if (cmd_reg.op == mftr_pkg::OP_DELETE)
                    begin
                        valid_next[pick_id] = 1'b0;
                        fl_we               = 1'b1;
                        cnt_next            = cnt_reg + 1'b1;
                    end
                end
                res_next.free_count = mftr_pkg::COUNT_W'(cnt_next);
            end

            mftr_pkg::ST_HEAD_TAKE:
            begin
                rule_we              = 1'b1;
                rule_idx             = fl_rd_data;
                valid_next[fl_rd_data] = 1'b1;
                head_next            = slot_of(head_reg, CNT_W'(1));
                cnt_next             = cnt_reg - 1'b1;
                res_next.status      = mftr_pkg::STAT_HIT;
                res_next.rule_id     = mftr_pkg::ID_W'(fl_rd_data);
                res_next.free_count  = mftr_pkg::COUNT_W'(cnt_next);
                res_valid_next       = 1'b1;
                state_next           = mftr_pkg::ST_IDLE;
            end

            mftr_pkg::ST_FIND_RD:
            begin
                state_next = mftr_pkg::ST_FIND_CHK;
            end

            mftr_pkg::ST_FIND_CHK:
            begin
                if (fl_rd_data == pos_idx)
                begin
                    state_next = mftr_pkg::ST_SHIFT_RD;
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = mftr_pkg::ST_FIND_RD;
                end
            end

            mftr_pkg::ST_SHIFT_RD:
            begin
                fl_rd_addr = slot_of(head_reg, walk_reg + 1'b1);
                if ((walk_reg + 1'b1) < cnt_reg)
                begin
                    state_next = mftr_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    rule_we             = 1'b1;
                    valid_next[pos_idx] = 1'b1;
                    cnt_next            = cnt_reg - 1'b1;
                    res_next.status     = mftr_pkg::STAT_HIT;
                    res_next.rule_id    = mftr_pkg::ID_W'(pos_idx);
                    res_next.free_count = mftr_pkg::COUNT_W'(cnt_next);
                    res_valid_next      = 1'b1;
                    state_next          = mftr_pkg::ST_IDLE;
                end
            end

            mftr_pkg::ST_SHIFT_WR:
            begin
                fl_we      = 1'b1;
                fl_wr_addr = slot_of(head_reg, walk_reg);
                fl_wr_data = fl_rd_data;
                walk_next  = walk_reg + 1'b1;
                state_next = mftr_pkg::ST_SHIFT_RD;
            end

            mftr_pkg::ST_FLUSH:
            begin
                fl_wr_data = flush_idx;
                if (valid_reg[flush_idx])
                begin
                    valid_next[flush_idx] = 1'b0;
                    fl_we                 = 1'b1;
                    cnt_next              = cnt_reg + 1'b1;
                end
                walk_next = walk_reg + 1'b1;
                if (walk_reg == CNT_W'(ENTRIES - 1))
                begin
                    res_next.status     = mftr_pkg::STAT_HIT;
                    res_next.rule_id    = '0;
                    res_next.free_count = mftr_pkg::COUNT_W'(cnt_next);
                    res_valid_next      = 1'b1;
                    state_next          = mftr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mftr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mftr_pkg::ST_IDLE;
            valid_reg     <= '0;
            head_reg      <= '0;
            cnt_reg       <= CNT_W'(ENTRIES);
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        hit_reg  <= hit_next;
        walk_reg <= walk_next;
        res_reg  <= res_next;
        if (rule_we)
        begin
            value_mem[rule_idx] <= cmd_reg.value;
            mask_mem[rule_idx]  <= cmd_reg.mask;
        end
    end

    assign done   = res_valid_reg;
    assign result = res_reg;

    `MFTR_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(ENTRIES))
    `MFTR_ASSERT_IMP(a_insert_free, clk, rst_n, rule_we, !valid_reg[rule_idx])
    `MFTR_ASSERT_NXT(a_reply_idle, clk, rst_n, res_valid_next, state_reg == mftr_pkg::ST_IDLE)

endmodule

`default_nettype wire

FILE: tb/sv/rule_table_checker.sv
module rule_table_checker
    import mftr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  request_t  request,
    input  wire logic done,
    input  result_t   result,
    output int        fail_count,
    output int        pending
);
    localparam int N = 64;

    tuple_t     rule_val [N];
    tuple_t     rule_msk [N];
    logic       rule_on  [N];
    logic [5:0] free_ids [$];
    result_t    expected_results [$];

    function automatic result_t predict_result(request_t rq);
        result_t r;
        tuple_t  v;
        tuple_t  m;
        int      k;
        v = {rq.src_ip, rq.dst_ip, rq.src_l4, rq.dst_l4, rq.proto};
        m = {rq.mask_src_ip, rq.mask_dst_ip, rq.mask_src_l4, rq.mask_dst_l4,
             rq.mask_proto};
        r.status = STAT_MISS;
        r.rule_id = '0;
        case (rq.mode)
            MODE_SEARCH:
                for (int i = 0; i < N; i++)
                    if (rule_on[i] && ((v ^ rule_val[i]) & rule_msk[i]) == '0)
                    begin
                        r.status = STAT_HIT;
                        r.rule_id = ID_W'(i);
                        break;
                    end
            MODE_INSERT:
                if (free_ids.size() == 0)
                    r.status = STAT_FULL;
                else
                begin
                    r.rule_id = free_ids.pop_front();
                    rule_val[r.rule_id] = v;
                    rule_msk[r.rule_id] = m;
                    rule_on[r.rule_id] = 1'b1;
                    r.status = STAT_HIT;
                end
            MODE_INSERT_AT:
                if (free_ids.size() == 0)
                    r.status = STAT_FULL;
                else
                begin
                    r.status = STAT_UNAVAIL;
                    k = -1;
                    foreach (free_ids[j])
                        if (k < 0 && free_ids[j] == rq.position)
                            k = j;
                    if (k >= 0)
                    begin
                        free_ids.delete(k);
                        r.rule_id = rq.position;
                        rule_val[r.rule_id] = v;
                        rule_msk[r.rule_id] = m;
                        rule_on[r.rule_id] = 1'b1;
                        r.status = STAT_HIT;
                    end
                end
            MODE_DELETE:
                for (int i = 0; i < N; i++)
                    if (rule_on[i] && rule_val[i] == v && rule_msk[i] == m)
                    begin
                        rule_on[i] = 1'b0;
                        free_ids.push_back(6'(i));
                        r.status = STAT_HIT;
                        r.rule_id = ID_W'(i);
                        break;
                    end
            MODE_DELETE_ALL:
            begin
                for (int i = 0; i < N; i++)
                    if (rule_on[i])
                    begin
                        rule_on[i] = 1'b0;
                        free_ids.push_back(6'(i));
                    end
                r.status = STAT_HIT;
            end
            default:
                r.status = STAT_MISS;
        endcase
        r.free_count = COUNT_W'(free_ids.size());
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_results.delete();
            free_ids.delete();
            for (int i = 0; i < N; i++)
            begin
                rule_on[i] = 1'b0;
                free_ids.push_back(6'(i));
            end
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %p", result);
                    fail_count <= fail_count + 1;
                end
                else if (expected_results[0] !== result)
                begin
                    if (fail_count < 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_results[0], result);
                    fail_count <= fail_count + 1;
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
            end
            if (start && !busy)
                expected_results.push_back(predict_result(request));
        end
    end
endmodule

FILE: tb/sv/tb_masked_five_tuple_rule_table.sv
module tb_masked_five_tuple_rule_table;
    import mftr_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;
    int       fail_count;
    int       pending;

    request_t rule_pool [$];

    masked_five_tuple_rule_table DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request),
        .busy(busy), .done(done), .result(result)
    );

    rule_table_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20000000;
        $display("FAIL masked_five_tuple_rule_table");
        $finish;
    end

    function automatic request_t random_request();
        request_t r;
        r.mode = 3'($urandom_range(0, 4));
        r.src_ip = $urandom;
        r.dst_ip = $urandom;
        r.src_l4 = 16'($urandom);
        r.dst_l4 = 16'($urandom);
        r.proto = 8'($urandom);
        r.mask_src_ip = $urandom;
        r.mask_dst_ip = $urandom;
        r.mask_src_l4 = 16'($urandom);
        r.mask_dst_l4 = 16'($urandom);
        r.mask_proto = 8'($urandom);
        r.position = 6'($urandom);
        return r;
    endfunction

    function automatic request_t well_formed();
        request_t r;
        int pick;
        r = random_request();
        if ($urandom_range(0, 2) == 0)
        begin
            r.mask_src_ip = '1 << $urandom_range(0, 32);
            r.mask_dst_ip = $urandom_range(0, 1) ? '0 : '1;
            r.mask_src_l4 = $urandom_range(0, 1) ? '0 : '1;
            r.mask_dst_l4 = $urandom_range(0, 1) ? '0 : '1;
            r.mask_proto = $urandom_range(0, 1) ? '0 : 8'hff;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
            r.mode = MODE_INSERT;
        else if (pick < 45)
            r.mode = MODE_INSERT_AT;
        else if (pick < 75)
            r.mode = MODE_SEARCH;
        else if (pick < 97)
            r.mode = MODE_DELETE;
        else if (pick < 99)
            r.mode = MODE_DELETE_ALL;
        else
            r.mode = 3'($urandom_range(5, 7));
        if (rule_pool.size() != 0 && (r.mode == MODE_SEARCH || r.mode == MODE_DELETE)
            && $urandom_range(0, 3) != 0)
        begin
            pick = $urandom_range(0, rule_pool.size() - 1);
            r.src_ip = rule_pool[pick].src_ip;
            r.dst_ip = rule_pool[pick].dst_ip;
            r.src_l4 = rule_pool[pick].src_l4;
            r.dst_l4 = rule_pool[pick].dst_l4;
            r.proto = rule_pool[pick].proto;
            if (r.mode == MODE_DELETE)
            begin
                r.mask_src_ip = rule_pool[pick].mask_src_ip;
                r.mask_dst_ip = rule_pool[pick].mask_dst_ip;
                r.mask_src_l4 = rule_pool[pick].mask_src_l4;
                r.mask_dst_l4 = rule_pool[pick].mask_dst_l4;
                r.mask_proto = rule_pool[pick].mask_proto;
            end
            else if ($urandom_range(0, 1))
                r.src_ip = r.src_ip ^ (32'h1 << $urandom_range(0, 31));
        end
        if (r.mode == MODE_INSERT || r.mode == MODE_INSERT_AT)
        begin
            rule_pool.push_back(r);
            if (rule_pool.size() > 80)
                rule_pool.delete(0);
        end
        return r;
    endfunction

    task automatic send(request_t r, int quiet);
        if (!quiet)
            while ($urandom_range(0, 99) < 9)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        start <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        request_t r;
        int guard;
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        r = '0;
        r.mode = MODE_SEARCH;
        send(r, 0);
        r = '1;
        r.mode = MODE_DELETE;
        send(r, 0);
        r.mode = 3'd7;
        send(r, 0);
        r.mode = 3'd5;
        send(r, 0);
        r.mode = MODE_INSERT;
        send(r, 0);
        rule_pool.push_back(r);
        r.mode = MODE_SEARCH;
        send(r, 0);
        r.mode = MODE_INSERT_AT;
        r.position = 6'd0;
        send(r, 0);
        r.position = 6'd63;
        r.mask_src_ip = '0;
        send(r, 0);
        r.position = 6'd5;
        send(r, 0);
        r.mode = MODE_DELETE;
        send(r, 0);
        r.mode = MODE_INSERT_AT;
        r.position = 6'd63;
        send(r, 0);
        for (int i = 0; i < 62; i++)
        begin
            r = random_request();
            r.mode = MODE_INSERT;
            send(r, 1);
        end
        r.mode = MODE_INSERT;
        send(r, 0);
        r.mode = MODE_INSERT_AT;
        send(r, 0);
        r.mode = MODE_SEARCH;
        send(r, 0);
        r.mode = MODE_DELETE_ALL;
        send(r, 0);
        send(r, 0);
        r = '0;
        r.mode = MODE_SEARCH;
        send(r, 0);

        for (int n = 0; n < 1270; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                r = random_request();
            else
                r = well_formed();
            send(r, n >= 500 && n < 700);
        end
        start <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS masked_five_tuple_rule_table");
        else
            $display("FAIL masked_five_tuple_rule_table");
        $finish;
    end
endmodule
